>>> sv/fsa_pkg.sv
// fsa_pkg: shared types and constants for the first-fit segment allocator
// used by fsa_ctrl, fsa_datapath, the top level and the checker
`default_nettype none

package fsa_pkg;

  // default depth of the segment table
  localparam int unsigned MaxSegmentsDef = 32;
  // byte count and offset width
  localparam int unsigned SizeW = 16;
  // pool size after reset
  localparam logic [SizeW-1:0] PoolSizeReset = 16'hFFFF;

  // result codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOFIT    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  // one table entry
  typedef struct packed {
    logic             used;
    logic [SizeW-1:0] size;
  } seg_t;

  // datapath commands, one per cycle
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_INIT,
    CMD_LOAD,
    CMD_READ_IDX,
    CMD_READ_NEXT,
    CMD_READ_SP,
    CMD_SCAN_STEP,
    CMD_ALLOC_HIT,
    CMD_FREE_HIT,
    CMD_NEXT_MERGE,
    CMD_MERGE_WR,
    CMD_SHUP_WR,
    CMD_SHDN_WR,
    CMD_SPLIT_WR,
    CMD_MARK_WR,
    CMD_FINISH
  } dp_cmd_e;

  // controller to datapath
  typedef struct packed {
    dp_cmd_e cmd;
    status_e status;
  } dp_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic init_pend;
    logic op_free;
    logic req_zero;
    logic fit;
    logic exact;
    logic full;
    logic last;
    logic match;
    logic zero_hit;
    logic merge_shift;
    logic shup_last;
    logic shdn_last;
    logic out_free;
  } dp_stat_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_NEXT_RD,
    S_NEXT_CHK,
    S_MERGE_WR,
    S_SHDN_RD,
    S_SHDN_WR,
    S_SHUP_RD,
    S_SHUP_WR,
    S_SPLIT_WR,
    S_MARK_WR,
    S_DONE
  } fsa_state_e;

endpackage

`default_nettype wire

>>> sv/fsa_datapath.sv
// fsa_datapath: segment table memory, scan and shift pointers, result register
// depends on fsa_pkg; driven by fsa_ctrl through dp_ctrl_t commands
`default_nettype none

module fsa_datapath #(
  parameter int unsigned MaxSegments = fsa_pkg::MaxSegmentsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [fsa_pkg::SizeW-1:0]    cfg_wdata_i,
  input  wire logic                         in_op_i,
  input  wire logic [fsa_pkg::SizeW-1:0]    in_req_i,
  input  wire logic [fsa_pkg::SizeW-1:0]    in_where_i,
  input  wire fsa_pkg::dp_ctrl_t            ctrl_i,
  output fsa_pkg::dp_stat_t                 stat_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output fsa_pkg::status_e                  out_status_o,
  output logic [fsa_pkg::SizeW-1:0]         out_offset_o
);
  import fsa_pkg::*;

  localparam int unsigned IW = $clog2(MaxSegments);
  localparam int unsigned CW = $clog2(MaxSegments + 1);

  // segment table storage
  seg_t mem [MaxSegments];

  logic [SizeW-1:0] pool_q;
  logic             init_q;
  logic [CW-1:0]    count_q;
  logic [IW-1:0]    idx_q;
  logic [IW-1:0]    sp_q;
  logic [SizeW-1:0] off_q;
  logic [SizeW-1:0] cur_q;
  seg_t             prev_q;
  logic [1:0]       k_q;
  logic             split_q;
  logic             op_q;
  logic [SizeW-1:0] req_q;
  logic [SizeW-1:0] where_q;
  seg_t             rd_q;
  logic             out_valid_q;
  status_e          out_status_q;
  logic [SizeW-1:0] out_offset_q;

  logic [CW-1:0]    idx_nx;
  logic             prev_merge;
  logic [1:0]       k_tot;
  logic [IW-1:0]    t_idx;
  logic [CW:0]      sp_start;
  logic [SizeW-1:0] total;
  logic             we;
  logic [IW-1:0]    wa;
  seg_t             wd;
  logic             rd_en;
  logic [IW-1:0]    ra;

  // merge geometry for a free item
  always_comb begin
    idx_nx     = CW'(idx_q) + CW'(1);
    prev_merge = (idx_q != '0) && !prev_q.used;
    k_tot      = k_q + {1'b0, prev_merge};
    t_idx      = prev_merge ? (idx_q - IW'(1)) : idx_q;
    sp_start   = (CW+1)'(t_idx) + (CW+1)'(1) + (CW+1)'(k_tot);
    total      = prev_merge ? (prev_q.size + cur_q) : cur_q;
  end

  // status toward the controller
  always_comb begin
    stat_o.init_pend   = init_q;
    stat_o.op_free     = op_q;
    stat_o.req_zero    = (req_q == '0);
    stat_o.fit         = !rd_q.used && (rd_q.size >= req_q);
    stat_o.exact       = (rd_q.size == req_q);
    stat_o.full        = (count_q == CW'(MaxSegments));
    stat_o.last        = (idx_nx == count_q);
    stat_o.match       = (off_q == where_q) && (off_q < pool_q);
    stat_o.zero_hit    = (pool_q == '0) && (where_q == '0);
    stat_o.merge_shift = (k_tot != 2'd0) && (sp_start < {1'b0, count_q});
    stat_o.shup_last   = (CW'(sp_q) == idx_nx);
    stat_o.shdn_last   = ((CW'(sp_q) + CW'(1)) == count_q);
    stat_o.out_free    = !out_valid_q || out_ready_i;
  end

  // memory port select
  always_comb begin
    we    = 1'b0;
    wa    = idx_q;
    wd    = rd_q;
    rd_en = 1'b0;
    ra    = idx_q;
    case (ctrl_i.cmd)
      CMD_INIT: begin
        we = 1'b1;
        wa = '0;
        wd = '{used: 1'b0, size: pool_q};
      end
      CMD_MERGE_WR: begin
        we = 1'b1;
        wa = t_idx;
        wd = '{used: 1'b0, size: total};
      end
      CMD_SHUP_WR: begin
        we = 1'b1;
        wa = sp_q + IW'(1);
        wd = rd_q;
      end
      CMD_SHDN_WR: begin
        we = 1'b1;
        wa = sp_q - IW'(k_q);
        wd = rd_q;
      end
      CMD_SPLIT_WR: begin
        we = 1'b1;
        wa = idx_q + IW'(1);
        wd = '{used: 1'b0, size: cur_q - req_q};
      end
      CMD_MARK_WR: begin
        we = 1'b1;
        wa = idx_q;
        wd = '{used: 1'b1, size: req_q};
      end
      CMD_READ_IDX: begin
        rd_en = 1'b1;
        ra    = idx_q;
      end
      CMD_READ_NEXT: begin
        rd_en = 1'b1;
        ra    = idx_q + IW'(1);
      end
      CMD_READ_SP: begin
        rd_en = 1'b1;
        ra    = sp_q;
      end
      default: begin
        we    = 1'b0;
        rd_en = 1'b0;
      end
    endcase
  end

  // table memory, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_q <= mem[ra];
    end
  end

  // control state: pool register, entry count, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q      <= PoolSizeReset;
      init_q      <= 1'b1;
      count_q     <= CW'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pool_q <= cfg_wdata_i;
        init_q <= 1'b1;
      end else if (ctrl_i.cmd == CMD_INIT) begin
        init_q <= 1'b0;
      end
      case (ctrl_i.cmd)
        CMD_INIT:    count_q <= CW'(1);
        CMD_MARK_WR: count_q <= count_q + CW'(split_q);
        CMD_FINISH:  count_q <= count_q - CW'(k_q);
        default:     count_q <= count_q;
      endcase
      if (ctrl_i.cmd == CMD_FINISH) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers of the current item
  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      CMD_LOAD: begin
        op_q    <= in_op_i;
        req_q   <= in_req_i;
        where_q <= in_where_i;
        idx_q   <= '0;
        off_q   <= '0;
        k_q     <= 2'd0;
        split_q <= 1'b0;
      end
      CMD_SCAN_STEP: begin
        off_q  <= off_q + rd_q.size;
        idx_q  <= idx_q + IW'(1);
        prev_q <= rd_q;
      end
      CMD_ALLOC_HIT: begin
        cur_q   <= rd_q.size;
        sp_q    <= IW'(count_q - CW'(1));
        split_q <= (rd_q.size != req_q);
      end
      CMD_FREE_HIT: begin
        cur_q <= rd_q.size;
      end
      CMD_NEXT_MERGE: begin
        if (!rd_q.used) begin
          cur_q <= cur_q + rd_q.size;
          k_q   <= 2'd1;
        end
      end
      CMD_MERGE_WR: begin
        sp_q <= IW'(sp_start);
        k_q  <= k_tot;
      end
      CMD_SHUP_WR: sp_q <= sp_q - IW'(1);
      CMD_SHDN_WR: sp_q <= sp_q + IW'(1);
      CMD_FINISH: begin
        out_status_q <= ctrl_i.status;
        out_offset_q <= ((ctrl_i.status == ST_OK) && !op_q) ? off_q : '0;
      end
      default: begin
        idx_q <= idx_q;
      end
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_offset_o = out_offset_q;

endmodule

`default_nettype wire

>>> sv/fsa_ctrl.sv
// fsa_ctrl: sequencer for scan, split, merge and table shifts
// depends on fsa_pkg; issues dp_ctrl_t commands to fsa_datapath
`default_nettype none

module fsa_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire fsa_pkg::dp_stat_t stat_i,
  output fsa_pkg::dp_ctrl_t      ctrl_o
);
  import fsa_pkg::*;

  fsa_state_e state_q, state_d;
  status_e    sts_q, sts_d;

  // state and pending result code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sts_q   <= ST_OK;
    end else begin
      state_q <= state_d;
      sts_q   <= sts_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d       = state_q;
    sts_d         = sts_q;
    in_ready_o    = 1'b0;
    ctrl_o.cmd    = CMD_NONE;
    ctrl_o.status = sts_q;
    case (state_q)
      S_IDLE: begin
        if (stat_i.init_pend) begin
          ctrl_o.cmd = CMD_INIT;
        end else begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            ctrl_o.cmd = CMD_LOAD;
            state_d    = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        ctrl_o.cmd = CMD_READ_IDX;
        state_d    = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (!stat_i.op_free) begin
          // allocate: first free segment that is big enough
          if (stat_i.req_zero) begin
            sts_d   = ST_NOFIT;
            state_d = S_DONE;
          end else if (stat_i.fit && stat_i.exact) begin
            ctrl_o.cmd = CMD_ALLOC_HIT;
            state_d    = S_MARK_WR;
          end else if (stat_i.fit && stat_i.full) begin
            sts_d   = ST_FULL;
            state_d = S_DONE;
          end else if (stat_i.fit) begin
            ctrl_o.cmd = CMD_ALLOC_HIT;
            state_d    = stat_i.last ? S_SPLIT_WR : S_SHUP_RD;
          end else begin
            ctrl_o.cmd = CMD_SCAN_STEP;
            if (stat_i.last) begin
              sts_d   = ST_NOFIT;
              state_d = S_DONE;
            end else begin
              state_d = S_SCAN_RD;
            end
          end
        end else begin
          // free: segment that starts at the given offset
          if (stat_i.match) begin
            ctrl_o.cmd = CMD_FREE_HIT;
            state_d    = stat_i.last ? S_MERGE_WR : S_NEXT_RD;
          end else begin
            ctrl_o.cmd = CMD_SCAN_STEP;
            if (stat_i.last) begin
              sts_d   = stat_i.zero_hit ? ST_OK : ST_NOTFOUND;
              state_d = S_DONE;
            end else begin
              state_d = S_SCAN_RD;
            end
          end
        end
      end
      S_NEXT_RD: begin
        ctrl_o.cmd = CMD_READ_NEXT;
        state_d    = S_NEXT_CHK;
      end
      S_NEXT_CHK: begin
        ctrl_o.cmd = CMD_NEXT_MERGE;
        state_d    = S_MERGE_WR;
      end
      S_MERGE_WR: begin
        ctrl_o.cmd = CMD_MERGE_WR;
        sts_d      = ST_OK;
        state_d    = stat_i.merge_shift ? S_SHDN_RD : S_DONE;
      end
      S_SHDN_RD: begin
        ctrl_o.cmd = CMD_READ_SP;
        state_d    = S_SHDN_WR;
      end
      S_SHDN_WR: begin
        ctrl_o.cmd = CMD_SHDN_WR;
        state_d    = stat_i.shdn_last ? S_DONE : S_SHDN_RD;
      end
      S_SHUP_RD: begin
        ctrl_o.cmd = CMD_READ_SP;
        state_d    = S_SHUP_WR;
      end
      S_SHUP_WR: begin
        ctrl_o.cmd = CMD_SHUP_WR;
        state_d    = stat_i.shup_last ? S_SPLIT_WR : S_SHUP_RD;
      end
      S_SPLIT_WR: begin
        ctrl_o.cmd = CMD_SPLIT_WR;
        state_d    = S_MARK_WR;
      end
      S_MARK_WR: begin
        ctrl_o.cmd = CMD_MARK_WR;
        sts_d      = ST_OK;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          ctrl_o.cmd = CMD_FINISH;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/first_fit_segment_allocator.sv
// first_fit_segment_allocator: top level, stream ports and configuration port
// depends on fsa_pkg, fsa_ctrl and fsa_datapath
//
// channel  | direction | fields (lsb first)
// s_axis   | in        | tuser: operation; tdata: request_size, block_offset
// m_axis   | out       | tdata: status, result_offset, zero pad to 24 bits
// cfg      | in        | cfg_wdata: pool_size, written when cfg_we is high
//
// one item at a time; the scan reads the single-port table memory with a read state
// and a check state per segment examined, and a split or merge moves every later
// entry with a read state and a write state for each entry
// after reset or a pool_size write an init command rewrites entry 0 before s_axis is ready
// the result register lets the next item be taken while m_axis is stalled
`default_nettype none

module first_fit_segment_allocator #(
  parameter int unsigned MaxSegments = fsa_pkg::MaxSegmentsDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  wire logic [31:0]               s_axis_tdata_i,  // request_size, block_offset
  input  wire logic                      s_axis_tuser_i,  // operation
  output logic                           m_axis_tvalid_o,
  input  wire logic                      m_axis_tready_i,
  output logic [23:0]                    m_axis_tdata_o,  // status, result_offset, pad
  input  wire logic                      cfg_we_i,
  input  wire logic [fsa_pkg::SizeW-1:0] cfg_wdata_i      // pool_size
);
  import fsa_pkg::*;

  dp_ctrl_t         ctrl;
  dp_stat_t         stat;
  status_e          out_status;
  logic [SizeW-1:0] out_offset;

  // sequencer
  fsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // table and result register
  fsa_datapath #(
    .MaxSegments (MaxSegments)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_op_i      (s_axis_tuser_i),
    .in_req_i     (s_axis_tdata_i[15:0]),
    .in_where_i   (s_axis_tdata_i[31:16]),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (out_status),
    .out_offset_o (out_offset)
  );

  // result packing
  assign m_axis_tdata_o = {6'b0, out_offset, out_status};

endmodule

`default_nettype wire

>>> sv/fsa_checker.sv
// fsa_checker: port-level assertions for first_fit_segment_allocator
// depends on fsa_pkg; bound to the top level below
`default_nettype none

module fsa_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [23:0] m_axis_tdata_o,
  input wire logic        cfg_we_i
);
  import fsa_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // a failed item carries offset zero
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[1:0] != ST_OK) |-> m_axis_tdata_o[17:2] == 16'd0)
    else $error("nonzero offset on failed item");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("item accepted while previous item in work");

  // a pool size write rebuilds the table before the next item
  a_cfg_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !s_axis_tready_o)
    else $error("ready during table rebuild");

endmodule

bind first_fit_segment_allocator fsa_checker u_fsa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .cfg_we_i        (cfg_we_i)
);

`default_nettype wire
